FILE: design/risa_pkg.sv
package risa_pkg;

   // Defaults for the top-level parameters.
   localparam int NUM_BLOCKS_DEF  = 7;
   localparam int MAX_SERVERS_DEF = 16;

   // Number of server-count registers on the configuration port.
   localparam int NUM_REGS = 7;

   // Field widths of the request and response items.
   localparam int ACT_W        = 2;
   localparam int BLK_W        = 3;
   localparam int SRV_W        = 4;
   localparam int RND_W        = 16;
   localparam int REQ_DATA_W   = 24;
   localparam int OUT_SRV_W    = 4;
   localparam int OUT_CNT_W    = 5;
   localparam int OUT_TOT_W    = 7;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 5;

   localparam logic [CSR_DATA_W-1:0] SERVERS_RESET [NUM_REGS] =
      '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd0};

   typedef enum logic [ACT_W-1:0] {
      ACT_ACQUIRE = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_QUERY   = 2'd2
   } action_type;

endpackage

FILE: design/random_idle_server_allocator.sv
// Random idle-server allocator: per-block busy bitmaps with random acquire, release and query.
// A request accepted on the port is held in the request register, then worked on and written
// into the response register once that register is empty or its response is being taken.
// Throughput: one request per cycle while rsp_tready holds; the bitmap select, one small
// multiply and the count update sit between the request register and the response register.
// Reset (synchronous, active high) marks every server idle and restores the server counts.
module random_idle_server_allocator #(
   parameter int NUM_BLOCKS  = risa_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_SERVERS = risa_pkg::MAX_SERVERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // block_index [2:0], release_srv [6:3], random_value [22:7], zero [23]
   input  logic [risa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action [1:0]
   input  logic [risa_pkg::ACT_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // server_out [3:0], busy_in_block [8:4], busy_total [15:9], any_busy [16], zero [23:17]
   output logic [risa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found [0]
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [risa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [risa_pkg::CSR_DATA_W-1:0]   csr_data
);
   import risa_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
   localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int TOT_W  = $clog2(NUM_BLOCKS * MAX_SERVERS + 1);
   localparam int PROD_W = CNT_W + RND_W;

   // Configuration and allocation state.
   logic [CSR_DATA_W-1:0]  servers_ff    [NUM_REGS];
   logic [MAX_SERVERS-1:0] busy_map_ff   [NUM_BLOCKS];
   logic [CNT_W-1:0]       busy_count_ff [NUM_BLOCKS];
   logic [TOT_W-1:0]       busy_total_ff;

   // Request register.
   logic             in_valid_ff;
   action_type       action_ff;
   logic [BLK_W-1:0] blk_ff;
   logic [SRV_W-1:0] srv_ff;
   logic [RND_W-1:0] rnd_ff;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [OUT_SRV_W-1:0] rsp_server_ff;
   logic [OUT_CNT_W-1:0] rsp_in_block_ff;
   logic [OUT_TOT_W-1:0] rsp_total_ff;
   logic                 rsp_any_ff;

   logic advance;

   // Working signals of the single pass.
   logic                   blk_valid;
   logic [MAX_SERVERS-1:0] map_sel;
   logic [CNT_W-1:0]       count_sel;
   logic [CSR_DATA_W-1:0]  servers_sel;
   logic [CSR_DATA_W-1:0]  present_n;
   logic [MAX_SERVERS-1:0] present_mask;
   logic [MAX_SERVERS-1:0] idle_mask;
   logic [MAX_SERVERS-1:0] busy_vis;
   logic [MAX_SERVERS-1:0] busy_low;
   logic [MAX_SERVERS-1:0] below;
   logic [MAX_SERVERS-1:0] pick_hot;
   logic [MAX_SERVERS-1:0] rel_hot;
   logic                   rel_hit;
   logic [CNT_W-1:0]       idle_cnt;
   logic [PROD_W-1:0]      product;
   logic [CNT_W-1:0]       pick;
   logic [IDX_W-1:0]       acq_idx;
   logic [IDX_W-1:0]       qry_idx;

   logic                   found_c;
   logic [IDX_W-1:0]       server_c;
   logic [MAX_SERVERS-1:0] busy_map_in;
   logic [CNT_W-1:0]       busy_count_in;
   logic [TOT_W-1:0]       busy_total_in;
   logic                   inc_c;
   logic                   dec_c;
   logic [CNT_W-1:0]       in_block_c;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      blk_valid   = 1'b0;
      map_sel     = '0;
      count_sel   = '0;
      servers_sel = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (int'(blk_ff) == b) begin
            blk_valid = 1'b1;
            map_sel   = busy_map_ff[b];
            count_sel = busy_count_ff[b];
         end
      end
      // Blocks without a register of their own have no servers.
      for (int r = 0; r < NUM_REGS; r++) begin
         if (int'(blk_ff) == r && r < NUM_BLOCKS) begin
            servers_sel = servers_ff[r];
         end
      end

      if (int'(servers_sel) > MAX_SERVERS) begin
         present_n = CSR_DATA_W'(MAX_SERVERS);
      end else begin
         present_n = servers_sel;
      end

      for (int i = 0; i < MAX_SERVERS; i++) begin
         present_mask[i] = (i < int'(present_n));
      end
      idle_mask = ~map_sel & present_mask;
      busy_vis  = map_sel & present_mask;

      idle_cnt = CNT_W'($countones(idle_mask));
      product  = PROD_W'(idle_cnt) * PROD_W'(rnd_ff);
      pick     = product[PROD_W-1:RND_W];

      // The chosen server is the idle one with exactly pick idle servers below it.
      for (int i = 0; i < MAX_SERVERS; i++) begin
         below       = idle_mask & ~({MAX_SERVERS{1'b1}} << i);
         pick_hot[i] = idle_mask[i] && (CNT_W'($countones(below)) == pick);
         rel_hot[i]  = (int'(srv_ff) == i);
      end
      rel_hit  = |(rel_hot & map_sel);
      busy_low = busy_vis & (~busy_vis + 1'b1);

      acq_idx = '0;
      qry_idx = '0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
         if (pick_hot[i]) begin
            acq_idx = acq_idx | IDX_W'(i);
         end
         if (busy_low[i]) begin
            qry_idx = qry_idx | IDX_W'(i);
         end
      end

      found_c       = 1'b0;
      server_c      = '0;
      busy_map_in   = map_sel;
      busy_count_in = count_sel;
      inc_c         = 1'b0;
      dec_c         = 1'b0;
      if (blk_valid) begin
         case (action_ff)
            ACT_ACQUIRE: begin
               if (idle_cnt != '0) begin
                  found_c       = 1'b1;
                  server_c      = acq_idx;
                  busy_map_in   = map_sel | pick_hot;
                  busy_count_in = count_sel + 1'b1;
                  inc_c         = 1'b1;
               end
            end
            ACT_RELEASE: begin
               // Releasing an idle server leaves the count alone.
               if (rel_hit) begin
                  busy_map_in   = map_sel & ~rel_hot;
                  busy_count_in = count_sel - 1'b1;
                  dec_c         = 1'b1;
               end
            end
            ACT_QUERY: begin
               if (|busy_vis) begin
                  found_c  = 1'b1;
                  server_c = qry_idx;
               end
            end
            default: begin
            end
         endcase
      end
      busy_total_in = busy_total_ff + TOT_W'(inc_c) - TOT_W'(dec_c);
      in_block_c    = blk_valid ? busy_count_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            servers_ff[r] <= SERVERS_RESET[r];
         end
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            busy_map_ff[b]   <= '0;
            busy_count_ff[b] <= '0;
         end
         busy_total_ff <= '0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            for (int r = 0; r < NUM_REGS; r++) begin
               if (int'(csr_index) == r && r < NUM_BLOCKS) begin
                  servers_ff[r] <= csr_data;
               end
            end
         end
         if (advance) begin
            for (int b = 0; b < NUM_BLOCKS; b++) begin
               if (blk_valid && int'(blk_ff) == b) begin
                  busy_map_ff[b]   <= busy_map_in;
                  busy_count_ff[b] <= busy_count_in;
               end
            end
            busy_total_ff <= busy_total_in;
         end
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         action_ff <= action_type'(req_tuser);
         blk_ff    <= req_tdata[BLK_W-1:0];
         srv_ff    <= req_tdata[BLK_W+SRV_W-1:BLK_W];
         rnd_ff    <= req_tdata[BLK_W+SRV_W+RND_W-1:BLK_W+SRV_W];
      end
      if (advance) begin
         rsp_found_ff    <= found_c;
         rsp_server_ff   <= OUT_SRV_W'(server_c);
         rsp_in_block_ff <= OUT_CNT_W'(in_block_c);
         rsp_total_ff    <= OUT_TOT_W'(busy_total_in);
         rsp_any_ff      <= (busy_total_in != '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - OUT_SRV_W - OUT_CNT_W - OUT_TOT_W - 1){1'b0}},
                        rsp_any_ff, rsp_total_ff, rsp_in_block_ff, rsp_server_ff};

   // A successful acquire adds exactly one busy server to the total.
   a_acquire_bumps_total: assert property (@(posedge clock) disable iff (reset)
      (advance && inc_c) |=> (busy_total_ff == $past(busy_total_ff) + 1'b1))
      else $error("total not incremented after acquire");

   // A release that hits a busy server removes exactly one from the total.
   a_release_drops_total: assert property (@(posedge clock) disable iff (reset)
      (advance && dec_c) |=> (busy_total_ff == $past(busy_total_ff) - 1'b1))
      else $error("total not decremented after release");

   // The total only moves when a request passes into the response register.
   a_total_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(busy_total_ff))
      else $error("total changed without a request");

   // A full request register behind a stalled response must refuse new requests.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while pipeline is full");

   // An acquire that succeeds marks exactly one idle server.
   a_one_pick: assert property (@(posedge clock) disable iff (reset)
      (advance && inc_c) |-> $onehot(pick_hot))
      else $error("acquire selected other than one server");

endmodule
